@@ rtl/amgs_pkg.sv @@
package amgs_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int DUMP_LIMIT       = 32;

  localparam int OP_W      = 3;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 6;
  localparam int STAT_W    = 2;
  localparam int ROW_OUT_W = 32;
  localparam int CNT_OUT_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_VERTEX = 3'd0,
    OP_REMOVE_VERTEX = 3'd1,
    OP_ADD_EDGE = 3'd2,
    OP_REMOVE_EDGE = 3'd3,
    OP_DUMP = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_RANGE = 2'd2,
    ST_EDGE = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    RD_SRC,
    RD_PTR,
    RD_A,
    RD_B
  } rsel_t;

  typedef enum logic [2:0] {
    WR_APPEND,
    WR_SHIFT,
    WR_CLEAR_TOP,
    WR_EDGE_A,
    WR_EDGE_B
  } wsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RM_RD,
    S_RM_WR,
    S_RM_CLR,
    S_E_RDA,
    S_E_WRA,
    S_E_RDB,
    S_E_WRB,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic  take_in;
    logic  stat_load;
    stat_t stat;
    logic  ptr_clr;
    logic  ptr_inc;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  rd_en;
    rsel_t rd_sel;
    logic  wr_en;
    wsel_t wr_sel;
    logic  out_load;
    logic  out_row;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic rm_bad;
    logic edge_bad;
    logic cnt_zero;
    logic walk_more;
    logic dump_last;
    logic out_free;
  } flags_t;

endpackage

@@ rtl/amgs_datapath.sv @@
module amgs_datapath
  import amgs_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [OP_W-1:0]      in_op,
  input  logic [VAL_W-1:0]     in_value,
  input  logic [IDX_W-1:0]     in_a,
  input  logic [IDX_W-1:0]     in_b,
  output flags_t               flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_row_valid,
  output logic [VAL_W-1:0]     out_value,
  output logic [ROW_OUT_W-1:0] out_row,
  output logic [CNT_OUT_W-1:0] out_count,
  output logic                 out_last
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int OW = (MAX_VERTICES < ROW_OUT_W) ? MAX_VERTICES : ROW_OUT_W;
  localparam int N  = MAX_VERTICES;

  op_t                op_q;
  logic [VAL_W-1:0]   val_in_q;
  logic [IDX_W-1:0]   a_q;
  logic [IDX_W-1:0]   b_q;
  logic [CW-1:0]      count;
  logic [AW-1:0]      ptr;
  stat_t              stat_q;

  logic [VAL_W-1:0]   val_mem [N];
  logic [N-1:0]       row_mem [N];
  logic [VAL_W-1:0]   val_rd;
  logic [N-1:0]       row_rd;

  logic [AW-1:0]      idx_a;
  logic [AW-1:0]      idx_b;
  logic [AW-1:0]      src;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [N-1:0]       wrow;
  logic [VAL_W-1:0]   wval;
  logic               val_we;
  logic [N-1:0]       lowmask;
  logic [N-1:0]       bit_a;
  logic [N-1:0]       bit_b;
  logic               set_edge;
  logic [XW-1:0]      cnt_x;
  logic [XW-1:0]      ptr_x1;
  logic [XW-1:0]      dump_n;
  logic [ROW_OUT_W-1:0] row32;

  assign idx_a    = AW'(a_q);
  assign idx_b    = AW'(b_q);
  assign cnt_x    = XW'(count);
  assign ptr_x1   = XW'(ptr) + XW'(1);
  assign dump_n   = (cnt_x > XW'(DUMP_LIMIT)) ? XW'(DUMP_LIMIT) : cnt_x;
  assign src      = (XW'(ptr) < XW'(a_q)) ? ptr : ptr + AW'(1);
  assign lowmask  = (N'(1) << idx_a) - N'(1);
  assign bit_a    = N'(1) << idx_a;
  assign bit_b    = N'(1) << idx_b;
  assign set_edge = (op_q == OP_ADD_EDGE);

  always_comb begin
    flags.op        = op_q;
    flags.full      = (count == CW'(MAX_VERTICES));
    flags.rm_bad    = (XW'(a_q) >= cnt_x);
    flags.edge_bad  = (XW'(a_q) >= cnt_x) || (XW'(b_q) >= cnt_x) || (a_q == b_q);
    flags.cnt_zero  = (count == '0);
    flags.walk_more = (ptr_x1 < cnt_x);
    flags.dump_last = (ptr_x1 == dump_n);
    flags.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SRC: raddr = src;
      RD_PTR: raddr = ptr;
      RD_A:   raddr = idx_a;
      RD_B:   raddr = idx_b;
    endcase
  end

  always_comb begin
    waddr  = ptr;
    wrow   = '0;
    wval   = val_rd;
    val_we = 1'b0;
    unique case (cmd.wr_sel)
      WR_APPEND: begin
        waddr  = AW'(count);
        wval   = val_in_q;
        val_we = cmd.wr_en;
      end
      WR_SHIFT: begin
        waddr  = ptr;
        // drop column idx_a: keep bits below it, pull the upper bits down
        wrow   = (row_rd & lowmask) | ((row_rd >> 1) & ~lowmask);
        val_we = cmd.wr_en;
      end
      WR_CLEAR_TOP: begin
        waddr = AW'(count - CW'(1));
      end
      WR_EDGE_A: begin
        waddr = idx_a;
        wrow  = set_edge ? (row_rd | bit_b) : (row_rd & ~bit_b);
      end
      WR_EDGE_B: begin
        waddr = idx_b;
        wrow  = set_edge ? (row_rd | bit_a) : (row_rd & ~bit_a);
      end
      default: begin
        waddr = ptr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      row_mem[waddr] <= wrow;
    end
    if (val_we) begin
      val_mem[waddr] <= wval;
    end
    if (cmd.rd_en) begin
      row_rd <= row_mem[raddr];
      val_rd <= val_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      op_q     <= op_t'(in_op);
      val_in_q <= in_value;
      a_q      <= in_a;
      b_q      <= in_b;
    end
    if (cmd.stat_load) begin
      stat_q <= cmd.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.ptr_clr) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + AW'(1);
      end
    end
  end

  always_comb begin
    row32 = '0;
    row32[OW-1:0] = row_rd[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count <= CNT_OUT_W'(count);
      if (cmd.out_row) begin
        out_status    <= ST_OK;
        out_row_valid <= 1'b1;
        out_value     <= val_rd;
        out_row       <= row32;
        out_last      <= flags.dump_last;
      end else begin
        out_status    <= stat_q;
        out_row_valid <= 1'b0;
        out_value     <= '0;
        out_row       <= '0;
        out_last      <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/amgs_ctrl.sv @@
module amgs_ctrl
  import amgs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  flags_t flags,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.stat   = ST_OK;
    cmd.rd_sel = RD_PTR;
    cmd.wr_sel = WR_APPEND;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.stat_load = 1'b1;
        cmd.ptr_clr   = 1'b1;
        state_next    = S_RESULT;
        unique case (flags.op)
          OP_ADD_VERTEX: begin
            if (flags.full) begin
              cmd.stat = ST_FULL;
            end else begin
              // new row goes in zeroed; its column is already clear in every row
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WR_APPEND;
              cmd.cnt_inc = 1'b1;
            end
          end
          OP_REMOVE_VERTEX: begin
            if (flags.rm_bad) begin
              cmd.stat = ST_RANGE;
            end else begin
              state_next = S_RM_RD;
            end
          end
          OP_ADD_EDGE, OP_REMOVE_EDGE: begin
            if (flags.edge_bad) begin
              cmd.stat = ST_EDGE;
            end else begin
              state_next = S_E_RDA;
            end
          end
          OP_DUMP: begin
            if (!flags.cnt_zero) begin
              state_next = S_DUMP_RD;
            end
          end
          default: begin
            cmd.stat = ST_OK;
          end
        endcase
      end
      S_RM_RD: begin
        if (flags.walk_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SRC;
          state_next = S_RM_WR;
        end else begin
          state_next = S_RM_CLR;
        end
      end
      S_RM_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.ptr_inc = 1'b1;
        state_next  = S_RM_RD;
      end
      S_RM_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_CLEAR_TOP;
        cmd.cnt_dec = 1'b1;
        state_next  = S_RESULT;
      end
      S_E_RDA: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_A;
        state_next = S_E_WRA;
      end
      S_E_WRA: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_EDGE_A;
        state_next = S_E_RDB;
      end
      S_E_RDB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_B;
        state_next = S_E_WRB;
      end
      S_E_WRB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_EDGE_B;
        state_next = S_RESULT;
      end
      S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
        state_next = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        // hold the read data until the output register frees up
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_row  = 1'b1;
          cmd.ptr_inc  = 1'b1;
          state_next   = flags.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      S_RESULT: begin
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/adjacency_matrix_graph_store.sv @@
// Undirected graph store: vertex values plus a symmetric adjacency bit matrix.
// Input stream: s_tuser carries the opcode (add vertex, remove vertex, add
// edge, remove edge, dump); s_tdata carries the new vertex value and the two
// vertex indices. One operation is taken at a time; s_tready is high only
// while the sequencer is idle, even if a result still waits on the output.
// Output stream: one transfer per operation, or one per stored vertex (up to
// 32) for a dump, with m_tlast on the final transfer of each operation and
// m_tuser high when the transfer carries a dumped row.
// Removal and dump are bound by the single read port and single write port
// of the row and value memories: each row is read, then rewritten or sent,
// before the next row is read.
// Reset clears the vertex count and the sequencer; the matrix needs no
// clearing pass since a row is zeroed when its vertex is added.
// A stall on m_tready holds the output register and, once a result or
// dumped row is waiting to be sent, the sequencer in place; nothing is dropped.
module adjacency_matrix_graph_store
  import amgs_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // new_vertex_value, first_index, second_index, zero pad
  input  logic [2:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // status, vertex_value, adjacency_row, vertex_count
  output logic [0:0]  m_tuser,   // row_valid
  output logic        m_tlast
);

  cmd_t   cmd;
  flags_t flags;

  logic [STAT_W-1:0]    out_status;
  logic                 out_row_valid;
  logic [VAL_W-1:0]     out_value;
  logic [ROW_OUT_W-1:0] out_row;
  logic [CNT_OUT_W-1:0] out_count;

  amgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  amgs_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_op         (s_tuser),
    .in_value      (s_tdata[31:0]),
    .in_a          (s_tdata[37:32]),
    .in_b          (s_tdata[43:38]),
    .flags         (flags),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_status    (out_status),
    .out_row_valid (out_row_valid),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_count     (out_count),
    .out_last      (m_tlast)
  );

  assign m_tdata    = {out_count, out_row, out_value, out_status};
  assign m_tuser[0] = out_row_valid;

endmodule

@@ tb/adjacency_matrix_graph_store_tb.sv @@
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_tb;
  import amgs_pkg::*;

  localparam int GRAPH_CAP       = MAX_VERTICES_DEF;
  localparam int RANDOM_OPS      = 96;
  localparam int HOLD_AFTER      = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam logic [OP_W-1:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [VAL_W-1:0] VAL_MIN        = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX        = 32'h7FFF_FFFF;
  localparam logic [IDX_W-1:0] IDX_TOP        = 6'd63;

  typedef struct {
    logic [OP_W-1:0]  opcode;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] second_idx;
  } graph_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]    status;
    logic                 row_valid;
    logic [VAL_W-1:0]     value;
    logic [ROW_OUT_W-1:0] row;
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
  } graph_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // new_vertex_value, first_index, second_index, zero pad
  logic [2:0]  s_tuser = '0;   // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // status, vertex_value, adjacency_row, vertex_count
  logic [0:0]  m_tuser;        // row_valid
  logic        m_tlast;

  adjacency_matrix_graph_store #(
    .MAX_VERTICES(GRAPH_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  // graph as the block should hold it
  logic [VAL_W-1:0]     vtx_val [GRAPH_CAP];
  logic [ROW_OUT_W-1:0] adj_row [GRAPH_CAP];
  int                   vtx_count = 0;

  graph_cmd_t    queued_ops[$];
  graph_result_t pending_results[$];

  int gen_count = 0;
  int ops_in = 0;
  int results_out = 0;
  int rows_dumped = 0;
  int full_refusals = 0;
  int peak_count = 0;
  int error_count = 0;

  logic in_taken = 1'b0;
  int   send_gap = 0;
  bit   send_burst = 1'b0;
  int   stall_left = 0;
  bit   recv_burst = 1'b0;
  bit   hold_done = 1'b0;
  int   idle_cycles = 0;

  function automatic int gap_length(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if (gen_count == 0 || $urandom_range(0, 99) < 15) return IDX_W'($urandom_range(0, 63));
    return IDX_W'($urandom_range(0, gen_count - 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return VAL_MIN;
    if (r == 1) return VAL_MAX;
    if (r == 2) return '0;
    if (r == 3) return '1;
    return $urandom();
  endfunction

  task automatic queue_op(input logic [OP_W-1:0] opcode, input logic [VAL_W-1:0] value,
                          input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
    graph_cmd_t c;
    c.opcode = opcode;
    c.value = value;
    c.first_idx = a;
    c.second_idx = b;
    queued_ops.push_back(c);
    // track the count so random indices land mostly in range
    if (opcode == OP_ADD_VERTEX && gen_count < GRAPH_CAP) gen_count++;
    if (opcode == OP_REMOVE_VERTEX && a < gen_count) gen_count--;
  endtask

  task automatic apply_graph_op(input logic [OP_W-1:0] opcode, input logic [VAL_W-1:0] value,
                                input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
    graph_result_t res;
    int n;
    int idx;
    res.status = ST_OK;
    res.row_valid = 1'b0;
    res.value = '0;
    res.row = '0;
    res.last = 1'b1;
    ops_in++;
    idx = a;
    case (opcode)
      OP_DUMP: begin
        n = (vtx_count > DUMP_LIMIT) ? DUMP_LIMIT : vtx_count;
        for (int i = 0; i < n; i++) begin
          res.row_valid = 1'b1;
          res.value = vtx_val[i];
          res.row = adj_row[i];
          res.count = CNT_OUT_W'(vtx_count);
          res.last = (i == n - 1);
          pending_results.push_back(res);
          rows_dumped++;
        end
      end
      OP_ADD_VERTEX: begin
        if (vtx_count >= GRAPH_CAP) begin
          res.status = ST_FULL;
          full_refusals++;
        end else begin
          vtx_val[vtx_count] = value;
          adj_row[vtx_count] = '0;
          for (int i = 0; i < vtx_count; i++) adj_row[i][vtx_count] = 1'b0;
          vtx_count++;
          if (vtx_count > peak_count) peak_count = vtx_count;
        end
      end
      OP_REMOVE_VERTEX: begin
        if (idx >= vtx_count) begin
          res.status = ST_RANGE;
        end else begin
          // pull later rows up, then squeeze the removed column out of every row
          for (int i = idx; i + 1 < vtx_count; i++) begin
            vtx_val[i] = vtx_val[i + 1];
            adj_row[i] = adj_row[i + 1];
          end
          vtx_count--;
          adj_row[vtx_count] = '0;
          for (int i = 0; i < vtx_count; i++)
            adj_row[i] = (adj_row[i] & ((32'd1 << idx) - 32'd1)) |
                         ((adj_row[i] >> (idx + 1)) << idx);
        end
      end
      OP_ADD_EDGE, OP_REMOVE_EDGE: begin
        if (a >= vtx_count || b >= vtx_count || a == b) begin
          res.status = ST_EDGE;
        end else begin
          adj_row[a][b] = (opcode == OP_ADD_EDGE);
          adj_row[b][a] = (opcode == OP_ADD_EDGE);
        end
      end
      default: ;
    endcase
    if (opcode != OP_DUMP || vtx_count == 0) begin
      res.count = CNT_OUT_W'(vtx_count);
      pending_results.push_back(res);
    end
  endtask

  task automatic check_result();
    graph_result_t want;
    results_out++;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: status %0d count %0d",
             m_tdata[1:0], m_tdata[71:66]);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    if (m_tdata[1:0] !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
      error_count++;
    end
    if (m_tuser[0] !== want.row_valid) begin
      $error("row_valid: expected %0d, got %0d", want.row_valid, m_tuser[0]);
      error_count++;
    end
    if (m_tdata[33:2] !== want.value) begin
      $error("vertex_value: expected %0d, got %0d",
             $signed(want.value), $signed(m_tdata[33:2]));
      error_count++;
    end
    if (m_tdata[65:34] !== want.row) begin
      $error("adjacency_row: expected %h, got %h", want.row, m_tdata[65:34]);
      error_count++;
    end
    if (m_tdata[71:66] !== want.count) begin
      $error("vertex_count: expected %0d, got %0d", want.count, m_tdata[71:66]);
      error_count++;
    end
    if (m_tlast !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, m_tlast);
      error_count++;
    end
  endtask

  // driver: hold the current item until its transfer, then gap or advance
  always @(negedge clk) begin
    graph_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (queued_ops.size() > 0) begin
        c = queued_ops.pop_front();
        s_tdata <= {4'b0, c.second_idx, c.first_idx, c.value};
        s_tuser <= c.opcode;
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 14) == 0) send_burst = !send_burst;
        send_gap <= gap_length(send_burst);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off while the sender keeps offering
  always @(negedge clk) begin
    int g;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && results_out >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      stall_left <= HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
      g = ($urandom_range(0, 2) == 0) ? gap_length(recv_burst) : 0;
      stall_left <= g;
      m_tready <= (g == 0);
    end
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        apply_graph_op(s_tuser, s_tdata[31:0], s_tdata[37:32], s_tdata[43:38]);
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) check_result();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("adjacency_matrix_graph_store_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    bit grow;

    // directed corners, starting from the empty graph
    queue_op(OP_DUMP, '0, '0, '0);
    queue_op(OP_REMOVE_VERTEX, '0, 6'd0, '0);
    queue_op(OP_ADD_EDGE, '0, 6'd0, 6'd1);
    queue_op(OP_SPARE_FIRST, VAL_MAX, IDX_TOP, IDX_TOP);
    queue_op(OP_ADD_VERTEX, VAL_MIN, '0, '0);
    queue_op(OP_ADD_VERTEX, VAL_MAX, IDX_TOP, IDX_TOP);
    queue_op(OP_ADD_VERTEX, '0, '0, '0);
    queue_op(OP_ADD_VERTEX, '1, '0, '0);
    queue_op(OP_ADD_EDGE, '0, 6'd0, 6'd1);
    queue_op(OP_ADD_EDGE, '0, 6'd3, 6'd0);
    queue_op(OP_ADD_EDGE, '0, 6'd2, 6'd2);
    queue_op(OP_ADD_EDGE, '0, 6'd1, IDX_TOP);
    queue_op(OP_REMOVE_EDGE, '0, IDX_TOP, 6'd0);
    queue_op(OP_ADD_EDGE, '0, 6'd1, 6'd2);
    queue_op(OP_DUMP, '0, '0, '0);
    queue_op(OP_REMOVE_EDGE, '0, 6'd1, 6'd0);
    queue_op(OP_REMOVE_EDGE, '0, 6'd1, 6'd0);
    queue_op(OP_REMOVE_VERTEX, '0, IDX_TOP, '0);
    queue_op(OP_REMOVE_VERTEX, '0, 6'd4, '0);
    queue_op(OP_REMOVE_VERTEX, '0, 6'd1, '0);
    queue_op(OP_DUMP, '0, '0, '0);
    queue_op(OP_SPARE_FIRST + 3'd1, '0, '0, '0);
    queue_op(OP_SPARE_LAST, '1, '0, '0);
    queue_op(OP_REMOVE_VERTEX, '0, 6'd2, '0);
    queue_op(OP_DUMP, '0, '0, '0);

    // first two thirds favour adds to grow the graph, the rest mixes removals back in
    for (int k = 0; k < RANDOM_OPS; k++) begin
      grow = (k < RANDOM_OPS * 2 / 3);
      r = $urandom_range(0, 99);
      a = pick_index();
      b = ($urandom_range(0, 99) < 6) ? a : pick_index();
      if (r < (grow ? 58 : 20))
        queue_op(OP_ADD_VERTEX, pick_value(), IDX_W'($urandom_range(0, 63)),
                 IDX_W'($urandom_range(0, 63)));
      else if (r < (grow ? 63 : 45))
        queue_op(OP_REMOVE_VERTEX, $urandom(), a, IDX_W'($urandom_range(0, 63)));
      else if (r < (grow ? 83 : 65))
        queue_op(OP_ADD_EDGE, $urandom(), a, b);
      else if (r < (grow ? 88 : 78))
        queue_op(OP_REMOVE_EDGE, $urandom(), a, b);
      else if (r < (grow ? 97 : 95))
        queue_op(OP_DUMP, $urandom(), IDX_W'($urandom_range(0, 63)),
                 IDX_W'($urandom_range(0, 63)));
      else
        queue_op(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), $urandom(), a, b);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (queued_ops.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d operations, checked %0d results including %0d dumped rows",
             ops_in, results_out, rows_dumped);
    $display("graph peaked at %0d vertices, %0d adds refused as full",
             peak_count, full_refusals);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("adjacency_matrix_graph_store_tb: done, clean");
    end else begin
      $display("adjacency_matrix_graph_store_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/amgs_pkg.sv
rtl/amgs_datapath.sv
rtl/amgs_ctrl.sv
rtl/adjacency_matrix_graph_store.sv
tb/adjacency_matrix_graph_store_tb.sv
